@@ sv/wbbd_pkg.sv @@
// Shared types, constants and window geometry of the window brightness bit decoder.
`timescale 1ns / 1ps

package wbbd_pkg;

  // Window geometry.
  localparam int WINDOW_SIZE = 16;
  localparam int NUM_WINDOWS = 7;
  localparam int MAX_WINDOWS = 8;

  // Field widths.
  localparam int CHAN_W   = 8;
  localparam int COORD_W  = 11;
  localparam int COUNT_W  = 9;
  localparam int SYMBOL_W = 7;

  // Coordinates plus the window size need one bit more than a coordinate.
  localparam int EXT_W = COORD_W + 1;

  // Stream and register port widths.
  localparam int IN_FIELDS_W = 3 * CHAN_W + 2 * COORD_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SYMBOL_W + 7) / 8) * 8;
  localparam int CFG_DATA_W  = COORD_W;
  localparam int CFG_IDX_W   = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes of the write port.
  localparam cfg_idx_t REG_BRIGHT_LEVEL  = 2'd0;
  localparam cfg_idx_t REG_MIN_LIT_COUNT = 2'd1;
  localparam cfg_idx_t REG_BAND_TOP_ROW  = 2'd2;

  // Reset values of the registers.
  localparam logic [CHAN_W-1:0]  BRIGHT_LEVEL_RST  = 8'd200;
  localparam logic [COUNT_W-1:0] MIN_LIT_COUNT_RST = 9'd40;
  localparam logic [COORD_W-1:0] BAND_TOP_ROW_RST  = 11'd270;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Fixed-point grey weights; they add up to one in Q14.
  localparam int GREY_FRAC = 14;
  localparam int GREY_W    = CHAN_W + GREY_FRAC;
  localparam logic [GREY_W-1:0] W_BLUE  = 22'd1868;
  localparam logic [GREY_W-1:0] W_GREEN = 22'd9617;
  localparam logic [GREY_W-1:0] W_RED   = 22'd4899;
  localparam logic [GREY_W-1:0] W_ROUND = 22'd8192;

  // First column of each window.
  localparam logic [COORD_W-1:0] WIN_START [MAX_WINDOWS] = '{
    11'd380, 11'd395, 11'd415, 11'd432, 11'd450, 11'd468, 11'd486, 11'd504
  };

  typedef logic [NUM_WINDOWS-1:0] win_vec_t;

endpackage

@@ sv/window_brightness_bit_decoder.sv @@
// Top level of the window brightness bit decoder: pixel pipeline, window counters, symbol output.
`timescale 1ns / 1ps

// Channel   | Dir | Handshake          | Contents
// s_*       | in  | s_tvalid/s_tready  | one pixel item, tlast marks the last pixel of a frame
// m_*       | out | m_tvalid/m_tready  | one 7-bit symbol item per frame
// cfg_*     | in  | cfg_we             | register writes, no read-back
//
// The block accepts one pixel item in every cycle unless the pipeline is held. A pixel
// passes an input register (stage A), where its grey value and window hits are formed,
// and a hit register (stage B), where the window counters are updated. A frame's symbol
// is registered onto m_* as its last pixel leaves stage B. Reset (rst, synchronous)
// empties the pipeline, clears the counters and loads the register reset values. Only a
// second frame-end item reaching stage B while a symbol waits on m_* holds the pipeline.

module window_brightness_bit_decoder (
  input  logic                             clk,
  input  logic                             rst,
  // Pixel input. s_tdata from bit 0: blue[7:0], green[15:8], red[23:16],
  // pixel_col[34:24], pixel_row[45:35], zero padding[47:46].
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [wbbd_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tlast,
  // Symbol output. m_tdata from bit 0: symbol[6:0], zero padding[7].
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [wbbd_pkg::OUT_TDATA_W-1:0] m_tdata,
  // Register write port.
  input  logic                             cfg_we,
  input  wbbd_pkg::cfg_idx_t               cfg_index,
  input  logic [wbbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import wbbd_pkg::*;

  // Configuration registers.
  logic [CHAN_W-1:0]  bright_level;
  logic [COUNT_W-1:0] min_lit_count;
  logic [COORD_W-1:0] band_top_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_level  <= BRIGHT_LEVEL_RST;
      min_lit_count <= MIN_LIT_COUNT_RST;
      band_top_row  <= BAND_TOP_ROW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BRIGHT_LEVEL:  bright_level  <= cfg_data[CHAN_W-1:0];
        REG_MIN_LIT_COUNT: min_lit_count <= cfg_data[COUNT_W-1:0];
        REG_BAND_TOP_ROW:  band_top_row  <= cfg_data[COORD_W-1:0];
        default: ;  // Writes past the register list are dropped.
      endcase
    end
  end

  // Pipeline control. Stage B only waits when it holds a frame end and the output
  // register still carries an untaken symbol.
  logic a_valid;
  logic b_valid;
  logic b_fend;
  logic a_go;
  logic b_go;

  assign b_go     = b_valid && (!b_fend || !m_tvalid || m_tready);
  assign a_go     = a_valid && (!b_valid || b_go);
  assign s_tready = !a_valid || a_go;

  // Stage A: the pixel as received.
  logic [CHAN_W-1:0]  a_blue;
  logic [CHAN_W-1:0]  a_green;
  logic [CHAN_W-1:0]  a_red;
  logic [COORD_W-1:0] a_col;
  logic [COORD_W-1:0] a_row;
  logic               a_fend;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_blue  <= s_tdata[CHAN_W-1:0];
      a_green <= s_tdata[2*CHAN_W-1:CHAN_W];
      a_red   <= s_tdata[3*CHAN_W-1:2*CHAN_W];
      a_col   <= s_tdata[3*CHAN_W+COORD_W-1:3*CHAN_W];
      a_row   <= s_tdata[3*CHAN_W+2*COORD_W-1:3*CHAN_W+COORD_W];
      a_fend  <= s_tlast;
    end
  end

  // Grey value, band test and window hits of the pixel in stage A.
  logic [GREY_W-1:0] grey_sum;
  logic [CHAN_W-1:0] grey;
  logic              lit;
  logic              in_band;
  win_vec_t          a_hit;

  always_comb begin
    grey_sum = W_BLUE * GREY_W'(a_blue) + W_GREEN * GREY_W'(a_green)
             + W_RED * GREY_W'(a_red) + W_ROUND;
    grey     = grey_sum[GREY_W-1:GREY_FRAC];
    lit      = grey > bright_level;
    // The band's upper bound is formed one bit wider so that it never wraps.
    in_band  = (a_row >= band_top_row)
            && (EXT_W'(a_row) < EXT_W'(band_top_row) + EXT_W'(WINDOW_SIZE));
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      a_hit[w] = lit && in_band && (a_col >= WIN_START[w])
              && (EXT_W'(a_col) < EXT_W'(WIN_START[w]) + EXT_W'(WINDOW_SIZE));
    end
  end

  // Stage B: which windows the pixel lands in.
  win_vec_t b_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!b_valid || b_go) begin
      b_valid <= a_go;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_hit  <= a_hit;
      b_fend <= a_fend;
    end
  end

  // Window counters. A frame-end pixel is counted before the symbol is formed,
  // then all counters clear. A counter stops at its top value.
  logic [COUNT_W-1:0] window_counts [NUM_WINDOWS];
  logic [COUNT_W-1:0] count_upd     [NUM_WINDOWS];
  win_vec_t           over;
  logic [SYMBOL_W-1:0] symbol_next;
  logic               counts_clear;

  always_comb begin
    symbol_next  = '0;
    counts_clear = 1'b1;
    for (int w = 0; w < NUM_WINDOWS; w++) begin
      count_upd[w] = (b_hit[w] && window_counts[w] != COUNT_MAX)
                   ? window_counts[w] + COUNT_W'(1) : window_counts[w];
      over[w]      = count_upd[w] > min_lit_count;
      if (window_counts[w] != '0) begin
        counts_clear = 1'b0;
      end
    end
    // The first window drives the highest bit; an eighth window has no place in the symbol.
    for (int k = 0; k < SYMBOL_W; k++) begin
      if (k < NUM_WINDOWS) begin
        symbol_next[k] = over[NUM_WINDOWS-1-k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WINDOWS; w++) begin
        window_counts[w] <= '0;
      end
    end else if (b_go) begin
      for (int w = 0; w < NUM_WINDOWS; w++) begin
        window_counts[w] <= b_fend ? '0 : count_upd[w];
      end
    end
  end

  // Output register.
  logic [SYMBOL_W-1:0] symbol;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b_go && b_fend) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_fend) begin
      symbol <= symbol_next;
    end
  end

  assign m_tdata = OUT_TDATA_W'(symbol);

  // A new symbol only ever follows a frame-end item leaving stage B.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(b_go && b_fend))
    else $error("symbol appeared without a frame end");

  // Every counter is zero once a frame has been closed.
  assert property (@(posedge clk) disable iff (rst)
    (b_go && b_fend) |=> counts_clear)
    else $error("window counters not cleared after frame end");

  // Ordinary pixels in stage B never wait on the output side.
  assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_fend) |-> b_go)
    else $error("pixel held in stage B");

  // The input is refused only while stage A is occupied and cannot move on.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (a_valid && b_valid && b_fend && m_tvalid && !m_tready))
    else $error("input refused without a waiting symbol");

endmodule
